[rtl/core/frcc_pkg.sv]
`timescale 1ns / 1ps

package frcc_pkg;

  localparam int RingSize = 16;
  localparam int PixW     = 8;
  localparam int ThrW     = 8;
  localparam int ArcW     = 5;
  localparam int CodeW    = 2 * RingSize;

  localparam logic [1:0] CodeSimilar  = 2'd0;
  localparam logic [1:0] CodeBrighter = 2'd1;
  localparam logic [1:0] CodeDarker   = 2'd2;

  localparam logic RegThreshold = 1'b0;
  localparam logic RegArcLength = 1'b1;

  // window ands over the ring: bit i covers pixels i .. i+n-1 (circular)
  typedef struct packed {
    logic [RingSize-1:0] r1;
    logic [RingSize-1:0] r2;
    logic [RingSize-1:0] r4;
    logic [RingSize-1:0] r8;
    logic [RingSize-1:0] r16;
  } span_t;

  function automatic logic [RingSize-1:0] rotr(input logic [RingSize-1:0] x,
                                               input logic [3:0] s);
    return (x >> s) | (x << (5'd16 - {1'b0, s}));
  endfunction

endpackage

[rtl/core/fast_ring_corner_classifier.sv]
// an accepted item passes the classify, span and arc match registers in turn; done rises with its result
// throughput: one item per cycle; busy never rises, so start may stay high
// done is a one-cycle strobe and the receiver cannot stall it
// stages: pixel classify, window span ands, arc length match
// synchronous reset empties the pipeline and sets threshold 30, arc length 9
`timescale 1ns / 1ps

module fast_ring_corner_classifier (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [frcc_pkg::PixW-1:0]             centre_pixel,
  input  logic [63:0]                           ring_low,
  input  logic [63:0]                           ring_high,
  input  logic                                  wr_en,
  input  logic                                  wr_index,
  input  logic [frcc_pkg::ThrW-1:0]             wr_data,
  output logic                                  done,
  output logic                                  corner_flag,
  output logic [frcc_pkg::CodeW-1:0]            feature_code
);

  logic [frcc_pkg::ThrW-1:0]        threshold;
  logic [frcc_pkg::ArcW-1:0]        arc_length;

  logic                             s1_valid;
  logic [frcc_pkg::RingSize-1:0]    s1_bright;
  logic [frcc_pkg::RingSize-1:0]    s1_dark;
  logic [frcc_pkg::CodeW-1:0]       s1_code;

  logic                             s2_valid;
  frcc_pkg::span_t                  s2_bright;
  frcc_pkg::span_t                  s2_dark;
  logic [frcc_pkg::CodeW-1:0]       s2_code;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= 8'd30;
      arc_length <= 5'd9;
    end else if (wr_en) begin
      case (wr_index)
        frcc_pkg::RegThreshold: threshold  <= wr_data;
        frcc_pkg::RegArcLength: arc_length <= wr_data[frcc_pkg::ArcW-1:0];
        default: ;
      endcase
    end
  end

  frcc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start & ~busy),
    .centre_pixel (centre_pixel),
    .ring_low     (ring_low),
    .ring_high    (ring_high),
    .threshold    (threshold),
    .valid        (s1_valid),
    .bright       (s1_bright),
    .dark         (s1_dark),
    .code         (s1_code)
  );

  frcc_span u_span (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s1_valid),
    .bright      (s1_bright),
    .dark        (s1_dark),
    .in_code     (s1_code),
    .valid       (s2_valid),
    .bright_span (s2_bright),
    .dark_span   (s2_dark),
    .code        (s2_code)
  );

  frcc_arc_match u_arc_match (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s2_valid),
    .bright_span  (s2_bright),
    .dark_span    (s2_dark),
    .in_code      (s2_code),
    .arc_length   (arc_length),
    .done         (done),
    .corner_flag  (corner_flag),
    .feature_code (feature_code)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("item accepted but no result three cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("result without an item taken three cycles earlier");

  a_no_bad_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((feature_code & (feature_code >> 1) & 32'h5555_5555) == 32'h0))
    else $error("pixel coded both brighter and darker");

  a_zero_arc: assert property (@(posedge clk) disable iff (rst)
    (done && $past(arc_length) == 5'd0) |-> corner_flag)
    else $error("zero arc length must always flag a corner");
`endif

endmodule

[rtl/core/frcc_classify.sv]
`timescale 1ns / 1ps

module frcc_classify (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [frcc_pkg::PixW-1:0]             centre_pixel,
  input  logic [63:0]                           ring_low,
  input  logic [63:0]                           ring_high,
  input  logic [frcc_pkg::ThrW-1:0]             threshold,
  output logic                                  valid,
  output logic [frcc_pkg::RingSize-1:0]         bright,
  output logic [frcc_pkg::RingSize-1:0]         dark,
  output logic [frcc_pkg::CodeW-1:0]            code
);

  logic signed [9:0]                    upper;
  logic signed [9:0]                    lower;
  logic [127:0]                         ring;
  logic [frcc_pkg::RingSize-1:0]        bright_next;
  logic [frcc_pkg::RingSize-1:0]        dark_next;
  logic [frcc_pkg::CodeW-1:0]           code_next;

  assign upper = $signed({2'b00, centre_pixel}) + $signed({2'b00, threshold});
  assign lower = $signed({2'b00, centre_pixel}) - $signed({2'b00, threshold});
  assign ring  = {ring_high, ring_low};

  always_comb begin
    logic signed [9:0] pix;
    bright_next = '0;
    dark_next   = '0;
    code_next   = '0;
    for (int k = 0; k < frcc_pkg::RingSize; k++) begin
      pix = $signed({2'b00, ring[8*k +: 8]});
      if (pix > upper) begin
        bright_next[k]        = 1'b1;
        code_next[2*k +: 2]   = frcc_pkg::CodeBrighter;
      end else if (pix < lower) begin
        dark_next[k]          = 1'b1;
        code_next[2*k +: 2]   = frcc_pkg::CodeDarker;
      end else begin
        code_next[2*k +: 2]   = frcc_pkg::CodeSimilar;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    bright <= bright_next;
    dark   <= dark_next;
    code   <= code_next;
  end

endmodule

[rtl/core/frcc_span.sv]
`timescale 1ns / 1ps

module frcc_span (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [frcc_pkg::RingSize-1:0]         bright,
  input  logic [frcc_pkg::RingSize-1:0]         dark,
  input  logic [frcc_pkg::CodeW-1:0]            in_code,
  output logic                                  valid,
  output frcc_pkg::span_t                       bright_span,
  output frcc_pkg::span_t                       dark_span,
  output logic [frcc_pkg::CodeW-1:0]            code
);

  frcc_pkg::span_t bright_next;
  frcc_pkg::span_t dark_next;

  function automatic frcc_pkg::span_t build(input logic [frcc_pkg::RingSize-1:0] m);
    frcc_pkg::span_t s;
    s.r1  = m;
    s.r2  = s.r1 & frcc_pkg::rotr(s.r1, 4'd1);
    s.r4  = s.r2 & frcc_pkg::rotr(s.r2, 4'd2);
    s.r8  = s.r4 & frcc_pkg::rotr(s.r4, 4'd4);
    s.r16 = s.r8 & frcc_pkg::rotr(s.r8, 4'd8);
    return s;
  endfunction

  assign bright_next = build(bright);
  assign dark_next   = build(dark);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    bright_span <= bright_next;
    dark_span   <= dark_next;
    code        <= in_code;
  end

endmodule

[rtl/core/frcc_arc_match.sv]
`timescale 1ns / 1ps

module frcc_arc_match (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  frcc_pkg::span_t                       bright_span,
  input  frcc_pkg::span_t                       dark_span,
  input  logic [frcc_pkg::CodeW-1:0]            in_code,
  input  logic [frcc_pkg::ArcW-1:0]             arc_length,
  output logic                                  done,
  output logic                                  corner_flag,
  output logic [frcc_pkg::CodeW-1:0]            feature_code
);

  logic flag_next;

  // window of len = and of two overlapping power-of-two windows
  function automatic logic span_hit(input frcc_pkg::span_t s,
                                    input logic [frcc_pkg::ArcW-1:0] len);
    logic [frcc_pkg::RingSize-1:0] base;
    logic [3:0]                    d;
    if (len[4]) begin
      base = s.r16;
      d    = 4'd0;
    end else if (len[3]) begin
      base = s.r8;
      d    = {1'b0, len[2:0]};
    end else if (len[2]) begin
      base = s.r4;
      d    = {2'b00, len[1:0]};
    end else if (len[1]) begin
      base = s.r2;
      d    = {3'b000, len[0]};
    end else begin
      base = s.r1;
      d    = 4'd0;
    end
    return |(base & frcc_pkg::rotr(base, d));
  endfunction

  always_comb begin
    if (arc_length == '0) begin
      flag_next = 1'b1;
    end else if (arc_length > 5'd16) begin
      flag_next = 1'b0;
    end else begin
      flag_next = span_hit(bright_span, arc_length) | span_hit(dark_span, arc_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    corner_flag  <= flag_next;
    feature_code <= in_code;
  end

endmodule
